/* rtl/rans_interleaved_decoder_top_defines.svh */
// ----------------------------------------------------------------------------
// rANS decoder assertion macros
// Shared concurrent assertion helpers for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef RANS_INTERLEAVED_DECODER_TOP_DEFINES_SVH
`define RANS_INTERLEAVED_DECODER_TOP_DEFINES_SVH

// Check an implication on every clock edge outside reset.
`define RID_ASSERT(label, clk_i, rst_n_i, prop, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (prop)) \
		else $error(msg);

// Check that a condition never holds outside reset.
`define RID_NEVER(label, clk_i, rst_n_i, cond, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) !(cond)) \
		else $error(msg);

`endif

/* rtl/rid_pkg.sv */
// ----------------------------------------------------------------------------
// rANS decoder package
// Request codes, status codes and the transaction types between the parts.
// ----------------------------------------------------------------------------
`default_nettype none
package rid_pkg;
	localparam logic [2:0] REQ_LOAD_FC   = 3'd0;
	localparam logic [2:0] REQ_LOAD_SLOT = 3'd1;
	localparam logic [2:0] REQ_INIT      = 3'd2;
	localparam logic [2:0] REQ_CTX       = 3'd3;
	localparam logic [2:0] REQ_BYPASS    = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EXHAUST  = 2'd1;
	localparam logic [1:0] ST_BAD_INIT = 2'd2;

	localparam logic [31:0] LOW_BOUND = 32'd65536;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [2:0]  lane;
		logic [4:0]  context_req;
		logic [3:0]  symbol;
		logic [11:0] slot;
		logic [12:0] frequency;
		logic [12:0] cumulative;
		logic [31:0] initial_state;
		logic [3:0]  bit_count;
		logic [15:0] next_half;
		logic        half_avail;
	} item_t;

	typedef struct packed {
		logic [11:0] decoded_value;
		logic        consumed;
		logic [1:0]  status;
	} result_t;
endpackage
`default_nettype wire

/* rtl/rans_interleaved_decoder_top.sv */
// Path: a load, init or unused item passes the item queue, the engine and the result
// queue; a decode also passes slot-map read, table read, multiply and renormalize.
// Throughput: one load/init per cycle while the result queue has room; a decode
// holds the engine busy over the dependent slot-map, table reads and lane update.
// Reset: arst_n clears lane states to zero and empties queues; tables are not cleared.
// ----------------------------------------------------------------------------
// rANS interleaved decoder top level
// Queue-style front end, decoupling queue, decode engine and result queue.
// ----------------------------------------------------------------------------
`default_nettype none
module rans_interleaved_decoder_top #(
	parameter int PROB_BITS = 12,
	parameter int LANES     = 8,
	parameter int CONTEXTS  = 32,
	parameter int SYMBOLS   = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  req_type,
	input  wire logic [2:0]  lane,
	input  wire logic [4:0]  context_req,
	input  wire logic [3:0]  symbol,
	input  wire logic [11:0] slot,
	input  wire logic [12:0] frequency,
	input  wire logic [12:0] cumulative,
	input  wire logic [31:0] initial_state,
	input  wire logic [3:0]  bit_count,
	input  wire logic [15:0] next_half,
	input  wire logic        half_avail,
	output logic             empty,
	input  wire logic        pop,
	output logic [11:0]      decoded_value,
	output logic             consumed,
	output logic [1:0]       status
);
	import rid_pkg::*;

	item_t   in_item, q_item;
	logic    q_empty, take;
	logic    res_valid, res_full;
	result_t res;
	logic    rq_empty;
	result_t rq_data;

	// Pack the transaction fields into one item word.
	assign in_item = '{req_type, lane, context_req, symbol, slot, frequency,
		cumulative, initial_state, bit_count, next_half, half_avail};

	rid_fifo u_front (
		.clk(clk), .arst_n(arst_n),
		.wr_en(push), .wr_data(in_item), .full(full),
		.rd_en(take), .rd_data(q_item), .empty(q_empty)
	);

	rid_engine #(
		.PROB_BITS(PROB_BITS), .LANES(LANES), .CONTEXTS(CONTEXTS), .SYMBOLS(SYMBOLS)
	) u_engine (
		.clk(clk), .arst_n(arst_n),
		.in_valid(!q_empty), .in_item(q_item), .in_take(take),
		.res_valid(res_valid), .res(res), .res_take(!res_full)
	);

	// Result queue: hold finished results until popped.
	result_t rq_mem_q [2];
	logic       rq_w_q, rq_r_q;
	logic [1:0] rq_cnt_q;
	logic       rq_wr, rq_rd;

	assign res_full = (rq_cnt_q == 2'd2);
	assign rq_empty = (rq_cnt_q == 2'd0);
	assign rq_wr    = res_valid && !res_full;
	assign rq_rd    = pop && !rq_empty;
	assign rq_data  = rq_mem_q[rq_r_q];

	always_ff @(posedge clk) begin
		if (rq_wr) rq_mem_q[rq_w_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_w_q   <= 1'b0;
			rq_r_q   <= 1'b0;
			rq_cnt_q <= 2'd0;
		end else begin
			if (rq_wr) rq_w_q <= ~rq_w_q;
			if (rq_rd) rq_r_q <= ~rq_r_q;
			rq_cnt_q <= rq_cnt_q + {1'b0, rq_wr} - {1'b0, rq_rd};
		end
	end

	assign empty         = rq_empty;
	assign decoded_value = rq_data.decoded_value;
	assign consumed      = rq_data.consumed;
	assign status        = rq_data.status;
endmodule
`default_nettype wire

/* rtl/rid_fifo.sv */
// ----------------------------------------------------------------------------
// rANS decoder item queue
// Two-entry queue that decouples the front from the decode engine.
// ----------------------------------------------------------------------------
`default_nettype none
module rid_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire rid_pkg::item_t wr_data,
	output logic                full,
	input  wire logic           rd_en,
	output rid_pkg::item_t      rd_data,
	output logic                empty
);
	import rid_pkg::*;
	item_t mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (wr_en && !full) wptr_q <= ~wptr_q;
			if (rd_en && !empty) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, wr_en && !full} - {1'b0, rd_en && !empty};
		end
	end
endmodule
`default_nettype wire

/* rtl/rid_engine.sv */
// ----------------------------------------------------------------------------
// rANS decode engine
// Owns the tables and lane states; runs one item through a short sequence.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rans_interleaved_decoder_top_defines.svh"
module rid_engine #(
	parameter int PROB_BITS = 12,
	parameter int LANES     = 8,
	parameter int CONTEXTS  = 32,
	parameter int SYMBOLS   = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire rid_pkg::item_t  in_item,
	output logic                 in_take,
	output logic                 res_valid,
	output rid_pkg::result_t     res,
	input  wire logic            res_take
);
	import rid_pkg::*;
	localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int CW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
	localparam int SW = $clog2(SYMBOLS);
	localparam int FC_DEPTH = CONTEXTS * SYMBOLS;
	localparam int FCW = $clog2(FC_DEPTH);
	localparam int SM_DEPTH = CONTEXTS * (1 << PROB_BITS);
	localparam int SMW = $clog2(SM_DEPTH);
	localparam int SYMW = 4;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SLOT = 2'd1;
	localparam logic [1:0] S_FC   = 2'd2;
	localparam logic [1:0] S_CALC = 2'd3;

	logic [SYMW-1:0] slot_mem [SM_DEPTH];
	logic [12:0]     freq_mem [FC_DEPTH];
	logic [12:0]     cum_mem  [FC_DEPTH];
	logic [31:0]     lane_q   [LANES];

	logic [1:0]  state_q;
	item_t       cur_q;
	logic [LW-1:0] ln_q;
	logic [CW-1:0] ctx_q;
	logic [31:0] x_q;
	logic [SYMW-1:0] sym_rd_q;
	logic [12:0] frq_rd_q, cum_rd_q;
	logic        res_valid_q;
	result_t     res_q;

	logic [LW-1:0] in_ln;
	logic [CW-1:0] in_ctx;
	logic [SW-1:0] in_sym;
	logic [PROB_BITS-1:0] in_slt;
	logic          busy;
	logic          res_set;
	logic [SW-1:0] v_sym;
	logic [31:0] hi;
	logic [PROB_BITS-1:0] s_low;
	logic [3:0]  nb;
	logic [31:0] x_new;
	logic [11:0] bp_v;
	logic [31:0] bp_x;

	// Reduce a small index modulo a constant with compare and subtract steps.
	function automatic int fold(input int v, input int m);
		int r;
		r = v;
		for (int k = 8; k >= 0; k--) begin
			if (r >= (m << k)) r = r - (m << k);
		end
		return r;
	endfunction

	assign in_ln  = LW'(fold(32'(in_item.lane), LANES));
	assign in_ctx = CW'(fold(32'(in_item.context_req), CONTEXTS));
	assign in_sym = SW'(fold(32'(in_item.symbol), SYMBOLS));
	assign in_slt = PROB_BITS'(in_item.slot);

	assign busy     = (state_q != S_IDLE) || (res_valid_q && !res_take);
	assign in_take  = in_valid && !busy;
	assign res_set  = (state_q == S_CALC) ||
		(in_take && in_item.req_type != REQ_CTX && in_item.req_type != REQ_BYPASS);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign hi    = x_q >> PROB_BITS;
	assign s_low = x_q[PROB_BITS-1:0];
	assign v_sym = SW'(fold(32'(sym_rd_q), SYMBOLS));
	assign nb    = (32'(cur_q.bit_count) > PROB_BITS) ? 4'(PROB_BITS) : cur_q.bit_count;

	always_comb begin
		logic [31:0] sh;
		logic [31:0] vv;
		sh   = 32'(PROB_BITS) - 32'(nb);
		vv   = 32'(s_low) >> sh;
		bp_v = vv[11:0];
		bp_x = (hi << sh) + 32'(s_low) - (vv << sh);
	end

	assign x_new = 32'(frq_rd_q) * hi + 32'(s_low) - 32'(cum_rd_q);

	// Slot map port
	always_ff @(posedge clk) begin
		if (in_take && in_item.req_type == REQ_LOAD_SLOT) begin
			slot_mem[SMW'({in_ctx, in_slt})] <= in_item.symbol;
		end
		sym_rd_q <= slot_mem[SMW'({ctx_q, x_q[PROB_BITS-1:0]})];
	end

	// Frequency and cumulative ports
	always_ff @(posedge clk) begin
		logic [FCW-1:0] wa, ra;
		wa = FCW'(32'(in_ctx) * SYMBOLS + 32'(in_sym));
		ra = FCW'(32'(ctx_q) * SYMBOLS + 32'(v_sym));
		if (in_take && in_item.req_type == REQ_LOAD_FC) begin
			freq_mem[wa] <= in_item.frequency;
			cum_mem[wa]  <= in_item.cumulative;
		end
		frq_rd_q <= freq_mem[ra];
		cum_rd_q <= cum_mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			for (int i = 0; i < LANES; i++) lane_q[i] <= '0;
		end else begin
			logic [31:0] xr;
			logic [11:0] vr;
			result_t     rr;
			xr = '0;
			vr = '0;
			rr = '0;
			if (res_set) res_valid_q <= 1'b1;
			else if (res_take) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						cur_q <= in_item;
						ln_q  <= in_ln;
						ctx_q <= in_ctx;
						x_q   <= lane_q[in_ln];
						unique case (in_item.req_type) inside
							REQ_CTX, REQ_BYPASS: state_q <= S_SLOT;
							REQ_INIT: begin
								if (in_item.initial_state < LOW_BOUND) begin
									rr.status = ST_BAD_INIT;
								end else begin
									lane_q[in_ln] <= in_item.initial_state;
								end
							end
							default: ;
						endcase
						res_q <= rr;
					end
				end
				S_SLOT: state_q <= S_FC;
				S_FC:   state_q <= S_CALC;
				S_CALC: begin
					if (cur_q.req_type == REQ_CTX) begin
						xr = x_new;
						vr = 12'(v_sym);
					end else begin
						xr = bp_x;
						vr = bp_v;
					end
					if (xr >= LOW_BOUND) begin
						lane_q[ln_q] <= xr;
						rr.decoded_value = vr;
					end else if (cur_q.half_avail) begin
						lane_q[ln_q] <= {xr[15:0], cur_q.next_half};
						rr.decoded_value = vr;
						rr.consumed = 1'b1;
					end else begin
						rr.status = ST_EXHAUST;
					end
					res_q <= rr;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RID_NEVER(a_no_take_busy, clk, arst_n, in_take && state_q != S_IDLE, "take while busy")
	`RID_ASSERT(a_calc_result, clk, arst_n, state_q == S_CALC |=> res_valid_q, "no result")
	`RID_NEVER(a_status_code, clk, arst_n, res_valid_q && res_q.status == 2'd3, "bad status")
	`RID_ASSERT(a_consume_ok, clk, arst_n, res_q.consumed |-> res_q.status == ST_OK, "bad consume")
endmodule
`default_nettype wire
